// ===== hdl/xrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_pkg
// Types and constants shared by the xoshiro256** random source.
// ----------------------------------------------------------------------------
package xrs_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned HALF_W  = 32;
	localparam int unsigned NWORDS  = 4;
	localparam int unsigned UNIT_SH = 11;

	localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;

	localparam logic [2:0] MUL_LAST = 3'd4;
	localparam logic [5:0] DIV_LAST = 6'd63;
	localparam logic [1:0] WORD_LAST = 2'd3;

	typedef enum logic [1:0] {
		REQ_RESEED  = 2'd0,
		REQ_RAW     = 2'd1,
		REQ_BOUNDED = 2'd2,
		REQ_UNIT    = 2'd3
	} req_code_t;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_MIX_ADD = 4'd1,
		ST_MUL     = 4'd2,
		ST_MIX_2   = 4'd3,
		ST_MIX_3   = 4'd4,
		ST_DRAW    = 4'd5,
		ST_LEM     = 4'd6,
		ST_DIV     = 4'd7,
		ST_DONE    = 4'd8
	} state_t;

endpackage

// ===== hdl/xrs_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_cfg_if
// Seed register write channel.
// ----------------------------------------------------------------------------
interface xrs_cfg_if
	import xrs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] seed_value;

	modport source (output valid, output seed_value, input ready);
	modport sink   (input valid, input seed_value, output ready);
endinterface

// ===== hdl/xrs_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_req_if
// Request channel: request type and bound.
// ----------------------------------------------------------------------------
interface xrs_req_if
	import xrs_pkg::*;
();
	logic              valid;
	logic              ready;
	req_code_t         req_type;
	logic [WORD_W-1:0] bound;

	modport source (output valid, output req_type, output bound, input ready);
	modport sink   (input valid, input req_type, input bound, output ready);
endinterface

// ===== hdl/xrs_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_rsp_if
// Result channel: one 64-bit value per item.
// ----------------------------------------------------------------------------
interface xrs_rsp_if
	import xrs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ===== hdl/xoshiro256ss_random_source.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro256ss_random_source
// xoshiro256** generator with splitmix64 seeding, raw, unit and bounded draws.
// ----------------------------------------------------------------------------
// channel  dir  payload                     item
// cfg      in   seed_value[63:0]            seed register write
// req      in   req_type[1:0], bound[63:0]  one request
// rsp      out  value[63:0]                 one result per request
//
// Raw and unit draws: ST_DRAW steps the generator, then ST_DONE registers the result.
// Reseed: per word an add, two 64x64 products, each as four 32x32 partial
// products on the shared multiplier, and two mix steps.
// Bounded: step, product and compare, a zero bound giving zero; each redraw
// repeats them, the threshold remainder is computed once (one quotient bit a cycle).
// After reset req.ready stays low while seed zero is expanded.
// req.ready is high only when idle; a held result stalls only the next finish.
// ----------------------------------------------------------------------------
module xoshiro256ss_random_source
	import xrs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	xrs_cfg_if.sink        cfg,
	xrs_req_if.sink        req,
	xrs_rsp_if.source      rsp
);

	state_t state_q, state_d, mul_ret_q;

	logic [WORD_W-1:0]   seed_q, acc_q;
	logic                init_q, thr_ok_q, out_valid_q;
	logic [1:0]          cnt_q;
	logic [2:0]          mstep_q;
	logic [5:0]          div_cnt_q;
	req_code_t           req_q;
	logic [WORD_W-1:0]   bound_q, mul_a_q, mul_b_q, res_q, out_value_q;
	logic [WORD_W-1:0]   rem_q, dvd_q;
	logic [2*WORD_W-1:0] prod_q;
	logic [WORD_W-1:0]   pp_q;
	logic [1:0]          pp_sh_q;
	logic [WORD_W-1:0]   gen_q [NWORDS];

	logic                accept, finish;
	logic [WORD_W-1:0]   sum, lo, hi, s1x5, rot1, draw_res, mix_word;
	logic [WORD_W-1:0]   n0, n1, n2, n3;
	logic [HALF_W-1:0]   a_half, b_half;
	logic [2*WORD_W-1:0] pp_ext;
	logic [WORD_W:0]     div_t, div_diff;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.value = out_value_q;

	assign accept = req.valid && (state_q == ST_IDLE);
	assign finish = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	assign sum      = acc_q + GOLDEN_GAMMA;
	assign lo       = prod_q[WORD_W-1:0];
	assign hi       = prod_q[2*WORD_W-1:WORD_W];
	assign mix_word = lo ^ (lo >> 31);

	// generator step
	assign s1x5     = gen_q[1] + (gen_q[1] << 2);
	assign rot1     = {s1x5[56:0], s1x5[63:57]};
	assign draw_res = rot1 + (rot1 << 3);
	assign n2       = gen_q[2] ^ gen_q[0];
	assign n3       = gen_q[3] ^ gen_q[1];
	assign n1       = gen_q[1] ^ n2;
	assign n0       = gen_q[0] ^ n3;

	// shared multiplier operand halves
	assign a_half = mstep_q[1] ? mul_a_q[WORD_W-1:HALF_W] : mul_a_q[HALF_W-1:0];
	assign b_half = mstep_q[0] ? mul_b_q[WORD_W-1:HALF_W] : mul_b_q[HALF_W-1:0];

	always_comb begin
		unique case (pp_sh_q)
			2'd0:    pp_ext = {{WORD_W{1'b0}}, pp_q};
			2'd3:    pp_ext = {pp_q, {WORD_W{1'b0}}};
			default: pp_ext = {{HALF_W{1'b0}}, pp_q, {HALF_W{1'b0}}};
		endcase
	end

	// restoring remainder step
	assign div_t    = {rem_q, dvd_q[WORD_W-1]};
	assign div_diff = div_t - {1'b0, bound_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MIX_ADD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					priority if (req.req_type == REQ_RESEED) begin
						state_d = ST_MIX_ADD;
					end else if (req.req_type == REQ_BOUNDED && req.bound == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_DRAW;
					end
				end
			end
			ST_MIX_ADD: state_d = ST_MUL;
			ST_MUL: begin
				if (mstep_q == MUL_LAST) begin
					state_d = mul_ret_q;
				end
			end
			ST_MIX_2: state_d = ST_MUL;
			ST_MIX_3: begin
				if (cnt_q == WORD_LAST) begin
					state_d = init_q ? ST_IDLE : ST_DONE;
				end else begin
					state_d = ST_MIX_ADD;
				end
			end
			ST_DRAW: state_d = (req_q == REQ_BOUNDED) ? ST_MUL : ST_DONE;
			ST_LEM: begin
				priority if (!thr_ok_q) begin
					state_d = (lo >= bound_q) ? ST_DONE : ST_DIV;
				end else if (lo < rem_q) begin
					state_d = ST_DRAW;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_LEM;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			acc_q       <= '0;
			init_q      <= 1'b1;
			cnt_q       <= '0;
			mstep_q     <= '0;
			div_cnt_q   <= '0;
			thr_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				seed_q <= cfg.seed_value;
			end
			if (accept) begin
				cnt_q    <= '0;
				thr_ok_q <= 1'b0;
				if (req.req_type == REQ_RESEED) begin
					acc_q <= seed_q;
				end
			end
			if (state_q == ST_MIX_ADD) begin
				acc_q <= sum;
			end
			if (state_q == ST_MIX_3) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == WORD_LAST) begin
					init_q <= 1'b0;
				end
			end
			mstep_q   <= (state_q == ST_MUL) ? mstep_q + 3'd1 : '0;
			div_cnt_q <= (state_q == ST_DIV) ? div_cnt_q + 6'd1 : '0;
			if (state_q == ST_DIV && div_cnt_q == DIV_LAST) begin
				thr_ok_q <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req.req_type;
			bound_q <= req.bound;
			res_q   <= '0;
		end
		unique case (state_q)
			ST_MIX_ADD: begin
				mul_a_q   <= sum ^ (sum >> 30);
				mul_b_q   <= MIX_MUL_A;
				mul_ret_q <= ST_MIX_2;
				prod_q    <= '0;
			end
			ST_MUL: begin
				if (mstep_q != MUL_LAST) begin
					pp_q    <= a_half * b_half;
					pp_sh_q <= mstep_q[1:0];
				end
				if (mstep_q != '0) begin
					prod_q <= prod_q + pp_ext;
				end
			end
			ST_MIX_2: begin
				mul_a_q   <= lo ^ (lo >> 27);
				mul_b_q   <= MIX_MUL_B;
				mul_ret_q <= ST_MIX_3;
				prod_q    <= '0;
			end
			ST_MIX_3: begin
				gen_q[cnt_q] <= mix_word;
				res_q        <= '0;
			end
			ST_DRAW: begin
				gen_q[0]  <= n0;
				gen_q[1]  <= n1;
				gen_q[2]  <= n2 ^ (gen_q[1] << 17);
				gen_q[3]  <= {n3[18:0], n3[63:19]};
				res_q     <= (req_q == REQ_UNIT) ? (draw_res >> UNIT_SH) : draw_res;
				mul_a_q   <= draw_res;
				mul_b_q   <= bound_q;
				mul_ret_q <= ST_LEM;
				prod_q    <= '0;
			end
			ST_LEM: begin
				res_q <= hi;
				if (!thr_ok_q) begin
					rem_q <= '0;
					dvd_q <= '0 - bound_q;
				end
			end
			ST_DIV: begin
				rem_q <= div_diff[WORD_W] ? div_t[WORD_W-1:0] : div_diff[WORD_W-1:0];
				dvd_q <= dvd_q << 1;
			end
			ST_DONE: begin
				if (finish) begin
					out_value_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while busy");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside finish");

	a_zero_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_BOUNDED && req.bound == '0)
		|=> (state_q == ST_DONE && res_q == '0))
		else $error("zero bound did not give zero");

	a_thr_below_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(thr_ok_q && state_q == ST_LEM) |-> (rem_q < bound_q))
		else $error("rejection threshold not below bound");

	a_mul_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mstep_q == MUL_LAST) |=> (state_q != ST_MUL))
		else $error("multiplier sequence overran");

endmodule

// ===== sim/xrs_draw_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrs_draw_check
// Passive checker for the xoshiro256** random source. It watches the seed,
// request and result channels and keeps its own copy of the generator words
// and the seed register. Each accepted request is turned into the value the
// block should return, and each accepted result is compared in order.
// ----------------------------------------------------------------------------
module xrs_draw_check
	import xrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [WORD_W-1:0] cfg_seed,
	input  logic              req_valid,
	input  logic              req_ready,
	input  req_code_t         req_type,
	input  logic [WORD_W-1:0] req_bound,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic [WORD_W-1:0] rsp_value,
	output int unsigned       fail_count,
	output int unsigned       pending
);

	typedef struct {
		req_code_t         kind;
		logic [WORD_W-1:0] bound;
		logic [WORD_W-1:0] value;
	} draw_expect_t;

	logic [WORD_W-1:0] seed_reg;
	logic [WORD_W-1:0] gen [NWORDS];
	draw_expect_t      awaited [$];

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int unsigned r);
		return (v << r) | (v >> (WORD_W - r));
	endfunction

	function automatic logic [WORD_W-1:0] mix_next(inout logic [WORD_W-1:0] acc);
		logic [WORD_W-1:0] z;
		acc = acc + GOLDEN_GAMMA;
		z = acc;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	function void expand_seed(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] acc;
		acc = s;
		for (int i = 0; i < NWORDS; i++)
			gen[i] = mix_next(acc);
	endfunction

	function logic [WORD_W-1:0] step_gen();
		logic [WORD_W-1:0] res;
		logic [WORD_W-1:0] t;
		res = rotl(gen[1] * 64'd5, 7) * 64'd9;
		t = gen[1] << 17;
		gen[2] = gen[2] ^ gen[0];
		gen[3] = gen[3] ^ gen[1];
		gen[1] = gen[1] ^ gen[2];
		gen[0] = gen[0] ^ gen[3];
		gen[2] = gen[2] ^ t;
		gen[3] = rotl(gen[3], 45);
		return res;
	endfunction

	// multiply-shift; low word under the bound triggers the rejection test
	function logic [WORD_W-1:0] pick_below(input logic [WORD_W-1:0] n);
		logic [2*WORD_W-1:0] prod;
		logic [WORD_W-1:0]   limit;
		if (n == '0)
			return '0;
		prod = {64'd0, step_gen()} * {64'd0, n};
		if (prod[WORD_W-1:0] < n) begin
			limit = (64'd0 - n) % n;
			while (prod[WORD_W-1:0] < limit)
				prod = {64'd0, step_gen()} * {64'd0, n};
		end
		return prod[2*WORD_W-1:WORD_W];
	endfunction

	function logic [WORD_W-1:0] next_value(input req_code_t kind, input logic [WORD_W-1:0] n);
		case (kind)
			REQ_RESEED: begin
				expand_seed(seed_reg);
				return '0;
			end
			REQ_RAW:     return step_gen();
			REQ_BOUNDED: return pick_below(n);
			default:     return step_gen() >> UNIT_SH;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		draw_expect_t e;
		if (!arst_n) begin
			seed_reg = '0;
			expand_seed('0);
			awaited.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result %h", $time, rsp_value);
					fail_count++;
				end else begin
					e = awaited.pop_front();
					if (rsp_value !== e.value) begin
						if (fail_count < 10)
							$display("%0t: %s item, bound %h: expected %h, got %h",
								$time, e.kind.name(), e.bound, e.value, rsp_value);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready) begin
				e.kind  = req_type;
				e.bound = req_bound;
				e.value = next_value(req_type, req_bound);
				awaited = {awaited, e};
			end
			if (cfg_valid && cfg_ready)
				seed_reg = cfg_seed;
			pending <= awaited.size();
		end
	end

endmodule

// ===== sim/xoshiro256ss_random_source_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro256ss_random_source_tb
// Stimulus and verdict for the xoshiro256** random source. A directed set
// covers the bound extremes, zero bound, heavy rejection, reseeding from
// both seed extremes and a long receiver stall; then random phases, each with
// a fresh seed, mix all request types under random idling on both sides,
// with one phase without gaps. Checking is done by xrs_draw_check.
// ----------------------------------------------------------------------------
module xoshiro256ss_random_source_tb;
	import xrs_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	xrs_cfg_if cfg_ch ();
	xrs_req_if req_ch ();
	xrs_rsp_if rsp_ch ();

	int unsigned fails;
	int unsigned pending;

	bit          src_steady;
	bit          snk_steady;
	bit          hold_ask;
	int unsigned stall_left;

	int unsigned n_reseed, n_raw, n_bounded, n_zero, n_unit, n_seeds;

	xoshiro256ss_random_source dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	xrs_draw_check draw_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_ch.valid),
		.cfg_ready  (cfg_ch.ready),
		.cfg_seed   (cfg_ch.seed_value),
		.req_valid  (req_ch.valid),
		.req_ready  (req_ch.ready),
		.req_type   (req_ch.req_type),
		.req_bound  (req_ch.bound),
		.rsp_valid  (rsp_ch.valid),
		.rsp_ready  (rsp_ch.ready),
		.rsp_value  (rsp_ch.value),
		.fail_count (fails),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random back-pressure, or a long hold when asked
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (hold_ask) begin
			stall_left = 300;
			hold_ask <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= snk_steady || ($urandom_range(99) >= 19);
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic issue(input req_code_t kind, input logic [WORD_W-1:0] bound);
		while (!src_steady && $urandom_range(99) < 19) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.bound    <= bound;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		case (kind)
			REQ_RESEED:  n_reseed++;
			REQ_RAW:     n_raw++;
			REQ_BOUNDED: begin
				n_bounded++;
				if (bound == '0)
					n_zero++;
			end
			default:     n_unit++;
		endcase
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_seed(input logic [WORD_W-1:0] s);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.seed_value <= s;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		n_seeds++;
	endtask

	initial begin
		req_code_t         kind;
		logic [WORD_W-1:0] bound;
		int unsigned       roll;

		arst_n            = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.seed_value = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_RAW;
		req_ch.bound      = '0;
		rsp_ch.ready      = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset state: seed zero expansion
		issue(REQ_RAW, rand_word());
		issue(REQ_UNIT, rand_word());
		issue(REQ_BOUNDED, '0);
		issue(REQ_BOUNDED, 64'd1);
		issue(REQ_BOUNDED, 64'd2);
		issue(REQ_BOUNDED, 64'd3);
		issue(REQ_BOUNDED, '1);
		issue(REQ_BOUNDED, 64'h8000_0000_0000_0001);
		issue(REQ_BOUNDED, 64'h8000_0000_0000_0000);
		issue(REQ_BOUNDED, 64'hC000_0000_0000_0001);
		issue(REQ_RESEED, '1);
		issue(REQ_RAW, '0);
		drain();

		write_seed('1);
		issue(REQ_RESEED, '0);
		issue(REQ_RAW, '1);
		issue(REQ_UNIT, '0);
		repeat (3) issue(REQ_BOUNDED, 64'h8000_0000_0000_0001);
		issue(REQ_BOUNDED, '0);
		drain();

		write_seed('0);
		issue(REQ_RESEED, rand_word());
		issue(REQ_UNIT, '1);
		drain();

		// long result hold while requests keep coming
		hold_ask <= 1'b1;
		repeat (8) issue(REQ_RAW, rand_word());
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			src_steady = (ph == 5);
			snk_steady <= (ph == 5);
			write_seed(rand_word());
			issue(REQ_RESEED, rand_word());
			repeat (120) begin
				roll = $urandom_range(99);
				if (roll < 8)
					kind = REQ_RESEED;
				else if (roll < 38)
					kind = REQ_RAW;
				else if (roll < 78)
					kind = REQ_BOUNDED;
				else
					kind = REQ_UNIT;
				roll = $urandom_range(99);
				if (roll < 10) begin
					bound = '0;
				end else if (roll < 35) begin
					bound = {32'd0, $urandom_range(1000, 1)};
				end else if (roll < 65) begin
					bound = rand_word();
					bound[WORD_W-1] = 1'b1;
				end else begin
					bound = rand_word();
				end
				issue(kind, bound);
			end
		end

		drain();
		repeat (60) @(posedge clk);
		$display("Run covered %0d reseeds, %0d raw, %0d bounded (%0d zero bound), %0d unit items",
			n_reseed, n_raw, n_bounded, n_zero, n_unit);
		$display("over %0d seed writes, with random idling and a long result stall", n_seeds);
		if (fails == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("Some tests failed");
		$finish;
	end

endmodule
